### hdl/imufp_pkg.sv
// ---------------------------------------------------------------------------
// imufp_pkg: shared definitions for the IMU frame parser
// Frame layout, sync and turn constants, and the packed result word.
// ---------------------------------------------------------------------------
package imufp_pkg;

	localparam int FRAME_BYTES_DEF = 18;

	localparam logic [7:0] SYNC_BYTE = 8'h5A;

	// byte offsets inside a frame (big-endian words)
	localparam int OFS_GYRO_X = 4;
	localparam int OFS_GYRO_Y = 6;
	localparam int OFS_GYRO_Z = 8;
	localparam int OFS_YAW    = 10;
	localparam int OFS_ROLL   = 12;
	localparam int OFS_PITCH  = 14;
	localparam int OFS_STATUS = 16;

	// 300.00 deg jump, 360.00 deg turn, turn count limit
	localparam logic signed [16:0] TURN_JUMP  = 17'sd30000;
	localparam logic signed [31:0] FULL_TURN  = 32'sd36000;
	localparam logic signed [15:0] TURN_LIMIT = 16'sd32767;

	// first field in the highest bits, so members run from the top down
	typedef struct packed {
		logic [15:0]        frames_seen;
		logic signed [31:0] unwrapped_yaw;
		logic signed [15:0] turn_total;
		logic [7:0]         device_status;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
		logic [15:0]        yaw_angle;
		logic signed [15:0] gyro_z;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_x;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

### hdl/imu_frame_parser_yaw_unwrap_core.sv
// ---------------------------------------------------------------------------
// imu_frame_parser_yaw_unwrap_core: IMU link frame parser with yaw unwrap
// Slides received bytes through a frame window, checks sync and sum,
// decodes the frame and keeps a saturating yaw turn count.
// ---------------------------------------------------------------------------
//
// Channel  Dir  Transaction                      Payload
// -------  ---  -------------------------------  ------------------------------
// s_axis   in   one link byte                    tdata[7:0] rx_byte,
//                                                tlast end_of_buffer
// m_axis   out  one decoded frame                tdata[167:0], see port list
//
// Cycles: one byte per cycle sustained while m_axis is not stalled. A byte is
// registered at the input stage, then window, checksum and turn logic run
// combinationally into the result register, so a frame's result passes the
// input stage and then the result register.
// Reset clears fill count, running sum, turn state and both valid flags;
// window bytes are only read once written since the last clear.
// A stall on m_axis holds the input stage whenever a result is waiting in
// the result register, whether or not the held byte completes a frame.

module imu_frame_parser_yaw_unwrap_core #(
	parameter int FRAME_BYTES = imufp_pkg::FRAME_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
	input  logic                           s_axis_tlast,  // end_of_buffer
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// gyro_x, gyro_y, gyro_z, yaw_angle, roll_angle, pitch_angle (16 each),
	// device_status (8), turn_total (16), unwrapped_yaw (32), frames_seen (16)
	output logic [imufp_pkg::RESULT_W-1:0] m_axis_tdata
);

	localparam int FILL_W = $clog2(FRAME_BYTES + 1);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;

	// window and running sum of the bytes held in it
	logic [7:0]        win_q [FRAME_BYTES];
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        sum_q;

	// yaw tracking
	logic [15:0]        prev_yaw_q;
	logic signed [15:0] turn_q;
	logic signed [31:0] offset_q;    // FULL_TURN * turn_q, kept incrementally
	logic [15:0]        frames_q;

	// result register
	logic                 out_valid_q;
	imufp_pkg::result_t   out_q;

	logic advance;
	logic full_old;
	logic ready_to_check;
	logic [7:0] win_nx [FRAME_BYTES];
	logic [7:0] cks;
	logic [7:0] sum_nx;
	logic match;
	logic [15:0] yaw_nx;
	logic signed [16:0] diff;
	logic signed [15:0] turn_nx;
	logic signed [31:0] offset_nx;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// ---- input stage ------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eob_s1  <= s_axis_tlast;
		end
	end

	// ---- next window ------------------------------------------------------
	// Full window: shift down by one, new byte at the end.
	// Filling: new byte lands at the fill position.
	assign full_old       = (fill_q == FILL_W'(FRAME_BYTES));
	assign ready_to_check = (fill_q >= FILL_W'(FRAME_BYTES - 1));

	for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_win
		if (i < FRAME_BYTES - 1) begin : g_mid
			assign win_nx[i] = full_old ? win_q[i+1] :
				((fill_q == FILL_W'(i)) ? byte_s1 : win_q[i]);
		end else begin : g_last
			assign win_nx[i] = (full_old || fill_q == FILL_W'(i)) ? byte_s1 : win_q[i];
		end
	end

	// checksum covers every byte but the new last one
	assign cks    = full_old ? (sum_q - win_q[0]) : sum_q;
	assign sum_nx = cks + byte_s1;

	assign match = ready_to_check
		&& (win_nx[0] == imufp_pkg::SYNC_BYTE)
		&& (win_nx[1] == imufp_pkg::SYNC_BYTE)
		&& (cks == byte_s1);

	// ---- yaw unwrap -------------------------------------------------------
	assign yaw_nx = {win_nx[imufp_pkg::OFS_YAW], win_nx[imufp_pkg::OFS_YAW+1]};
	assign diff   = $signed({1'b0, yaw_nx}) - $signed({1'b0, prev_yaw_q});

	always_comb begin
		turn_nx   = turn_q;
		offset_nx = offset_q;
		if (diff < -imufp_pkg::TURN_JUMP && turn_q < imufp_pkg::TURN_LIMIT) begin
			// dropped through zero: one turn up
			turn_nx   = turn_q + 16'sd1;
			offset_nx = offset_q + imufp_pkg::FULL_TURN;
		end else if (diff > imufp_pkg::TURN_JUMP && turn_q > -imufp_pkg::TURN_LIMIT) begin
			// rose through zero: one turn down
			turn_nx   = turn_q - 16'sd1;
			offset_nx = offset_q - imufp_pkg::FULL_TURN;
		end
	end

	// ---- state update -----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			sum_q       <= '0;
			prev_yaw_q  <= '0;
			turn_q      <= '0;
			offset_q    <= '0;
			frames_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				if (match || eob_s1) begin
					fill_q <= '0;
					sum_q  <= '0;
				end else begin
					fill_q <= full_old ? fill_q : fill_q + FILL_W'(1);
					sum_q  <= sum_nx;
				end
				if (match) begin
					prev_yaw_q <= yaw_nx;
					turn_q     <= turn_nx;
					offset_q   <= offset_nx;
					frames_q   <= frames_q + 16'd1;
				end
			end
			if (advance && match) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			win_q <= win_nx;
		end
		if (advance && match) begin
			out_q.gyro_x        <= {win_nx[imufp_pkg::OFS_GYRO_X], win_nx[imufp_pkg::OFS_GYRO_X+1]};
			out_q.gyro_y        <= {win_nx[imufp_pkg::OFS_GYRO_Y], win_nx[imufp_pkg::OFS_GYRO_Y+1]};
			out_q.gyro_z        <= {win_nx[imufp_pkg::OFS_GYRO_Z], win_nx[imufp_pkg::OFS_GYRO_Z+1]};
			out_q.yaw_angle     <= yaw_nx;
			out_q.roll_angle    <= {win_nx[imufp_pkg::OFS_ROLL], win_nx[imufp_pkg::OFS_ROLL+1]};
			out_q.pitch_angle   <= {win_nx[imufp_pkg::OFS_PITCH], win_nx[imufp_pkg::OFS_PITCH+1]};
			out_q.device_status <= win_nx[imufp_pkg::OFS_STATUS];
			out_q.turn_total    <= turn_nx;
			out_q.unwrapped_yaw <= offset_nx + $signed({16'd0, yaw_nx});
			out_q.frames_seen   <= frames_q + 16'd1;
		end
	end

endmodule

### hdl/imufp_checker.sv
// ---------------------------------------------------------------------------
// imufp_checker: port-level checks for the IMU frame parser
// Watches both stream channels and the decoded result word.
// ---------------------------------------------------------------------------
module imufp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [imufp_pkg::RESULT_W-1:0] m_axis_tdata
);

	imufp_pkg::result_t res;
	logic signed [31:0] expect_total;

	assign res          = m_axis_tdata;
	assign expect_total = $signed({16'd0, res.yaw_angle})
		+ imufp_pkg::FULL_TURN * 32'(res.turn_total);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// total yaw matches yaw and turn count
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res.unwrapped_yaw == expect_total)
		else $error("unwrapped yaw inconsistent with turn count");

	// turn count saturates symmetrically
	a_turn: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res.turn_total != 16'sh8000)
		else $error("turn count beyond limit");

	// a fresh result needs an earlier byte taken in through the input stage
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without a preceding byte");

endmodule

bind imu_frame_parser_yaw_unwrap_core imufp_checker u_imufp_checker (.*);

### test/tb_imu_frame_parser_yaw_unwrap_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_imu_frame_parser_yaw_unwrap_core: self-checking bench for the IMU parser
// Feeds link bytes as whole frames, damaged frames and noise, predicts every
// decoded frame, and compares each output transaction field by field.
// ---------------------------------------------------------------------------

module tb_imu_frame_parser_yaw_unwrap_core;

	localparam int FRAME_N     = imufp_pkg::FRAME_BYTES_DEF;
	localparam int RANDOM_LEN  = 1300;     // link bytes in the random part
	localparam int CYCLE_LIMIT = 100000;   // clock cycles before the run is called a failure
	localparam int JUMP_CENTI  = 30000;    // 300.00 deg
	localparam int TURN_CENTI  = 36000;    // 360.00 deg
	localparam int TURN_SAT    = 32767;

	// ways of damaging a frame on its way in
	typedef enum {
		FAULT_NONE,
		FAULT_SYNC0,      // first sync byte wrong
		FAULT_SYNC1,      // second sync byte wrong
		FAULT_SUM,        // checksum byte wrong
		FAULT_EOB_MID,    // end of buffer lands inside the frame
		FAULT_NOISE_LEAD  // stray bytes ahead of the frame
	} frame_fault_t;

	// one row of the directed table; the expectation is typed in only when
	// turns, unwrapped yaw and frame count are plain to see
	typedef struct {
		frame_fault_t fault;
		bit           eob_last;
		logic [15:0]  gx, gy, gz, yaw, roll, pitch;
		logic [7:0]   status;
		bit           typed;
		logic [15:0]  turns;
		logic [31:0]  unwrap;
		logic [15:0]  frames;
	} frame_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [7:0]                     s_axis_tdata;   // [7:0] rx_byte
	logic                           s_axis_tlast;   // end_of_buffer
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [imufp_pkg::RESULT_W-1:0] m_axis_tdata;   // gyro_x .. frames_seen, see result_t

	imu_frame_parser_yaw_unwrap_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// --- parser mirror: window, fill, last yaw, turns, frame count ---------
	logic [7:0]  link_win [FRAME_N];
	int          link_fill;
	logic [15:0] last_yaw;
	int          turn_count;
	logic [15:0] frame_count;

	imufp_pkg::result_t pending_frames [$];  // decoded frames still owed by the DUT
	imufp_pkg::result_t typed_result;        // directed row expectation, if any
	bit          typed_pending;
	logic [7:0]  frame_buf [FRAME_N];
	int          link_bytes_sent;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          errors;
	int          cycles = 0;

	frame_row_t  directed_rows [0:13];

	// clock, 20 ns
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// cycle counter and run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic void clear_link_win();
		int i;
		for (i = 0; i < FRAME_N; i++)
			link_win[i] = 8'h00;
		link_fill = 0;
	endfunction

	// Mirror of the parser for one accepted byte; returns 1 with the decoded
	// frame when the window now holds sync, body and a matching sum.
	function automatic bit decode_link_byte(input logic [7:0] b, input logic eob,
	                                        output imufp_pkg::result_t r);
		int         i;
		int         diff;
		logic [7:0] sum;
		logic [15:0] yaw;
		bit         hit;
		hit = 1'b0;
		r = '0;
		if (link_fill >= FRAME_N) begin
			for (i = 0; i < FRAME_N - 1; i++)
				link_win[i] = link_win[i + 1];
			link_win[FRAME_N - 1] = b;
		end else begin
			link_win[link_fill] = b;
			link_fill++;
		end
		if (link_fill == FRAME_N && link_win[0] == imufp_pkg::SYNC_BYTE
		    && link_win[1] == imufp_pkg::SYNC_BYTE) begin
			sum = 8'h00;
			for (i = 0; i < FRAME_N - 1; i++)
				sum = sum + link_win[i];
			if (sum == link_win[FRAME_N - 1]) begin
				yaw  = {link_win[10], link_win[11]};
				diff = int'(yaw) - int'(last_yaw);
				// big drop: yaw wrapped forwards; big rise: wrapped backwards
				if (diff < -JUMP_CENTI && turn_count < TURN_SAT)
					turn_count++;
				if (diff > JUMP_CENTI && turn_count > -TURN_SAT)
					turn_count--;
				last_yaw    = yaw;
				frame_count = frame_count + 16'd1;
				r.gyro_x        = {link_win[4], link_win[5]};
				r.gyro_y        = {link_win[6], link_win[7]};
				r.gyro_z        = {link_win[8], link_win[9]};
				r.yaw_angle     = yaw;
				r.roll_angle    = {link_win[12], link_win[13]};
				r.pitch_angle   = {link_win[14], link_win[15]};
				r.device_status = link_win[16];
				r.turn_total    = 16'(turn_count);
				r.unwrapped_yaw = 32'(int'(yaw) + TURN_CENTI * turn_count);
				r.frames_seen   = frame_count;
				hit = 1'b1;
				clear_link_win();
			end
		end
		if (eob)
			clear_link_win();
		return hit;
	endfunction

	// Lay out a well-formed frame in frame_buf: sync, spare word, big-endian
	// fields, status, 8-bit sum.
	function automatic void build_frame(input imufp_pkg::result_t f, input logic [15:0] spare);
		int         i;
		logic [7:0] sum;
		frame_buf[0]  = imufp_pkg::SYNC_BYTE;
		frame_buf[1]  = imufp_pkg::SYNC_BYTE;
		frame_buf[2]  = spare[15:8];
		frame_buf[3]  = spare[7:0];
		frame_buf[4]  = f.gyro_x[15:8];
		frame_buf[5]  = f.gyro_x[7:0];
		frame_buf[6]  = f.gyro_y[15:8];
		frame_buf[7]  = f.gyro_y[7:0];
		frame_buf[8]  = f.gyro_z[15:8];
		frame_buf[9]  = f.gyro_z[7:0];
		frame_buf[10] = f.yaw_angle[15:8];
		frame_buf[11] = f.yaw_angle[7:0];
		frame_buf[12] = f.roll_angle[15:8];
		frame_buf[13] = f.roll_angle[7:0];
		frame_buf[14] = f.pitch_angle[15:8];
		frame_buf[15] = f.pitch_angle[7:0];
		frame_buf[16] = f.device_status;
		sum = 8'h00;
		for (i = 0; i < FRAME_N - 1; i++)
			sum = sum + frame_buf[i];
		frame_buf[FRAME_N - 1] = sum;
	endfunction

	// Yaw near the turn threshold on either side, a small step from the last one, or anywhere at all.
	function automatic logic [15:0] pick_yaw();
		int d;
		int cand;
		case ($urandom_range(3))
			0: cand = $urandom_range(65535);
			1, 2: begin
				d = JUMP_CENTI - 5 + $urandom_range(10);
				cand = $urandom_range(1) ? int'(last_yaw) + d : int'(last_yaw) - d;
				if (cand > 65535 || cand < 0)
					cand = (cand > 65535) ? int'(last_yaw) - d : int'(last_yaw) + d;
			end
			default: begin
				cand = int'(last_yaw) + $urandom_range(1000) - 500;
				if (cand < 0)
					cand = 0;
				if (cand > 65535)
					cand = 65535;
			end
		endcase
		return 16'(cand);
	endfunction

	// One link byte: optional idle gap, then hold tvalid until taken.
	// tvalid is left high after the transaction so that back-to-back bytes
	// never see a low and a high assignment in the same step.
	task automatic push_byte(input logic [7:0] b, input logic eob);
		imufp_pkg::result_t r;
		bit      hit;
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eob;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		hit = decode_link_byte(b, eob, r);
		if (hit) begin
			if (typed_pending) begin
				pending_frames.push_back(typed_result);
				typed_pending = 1'b0;
			end else begin
				pending_frames.push_back(r);
			end
		end
		link_bytes_sent++;
	endtask

	// Send frame_buf, damaged as asked.
	task automatic send_frame(input frame_fault_t fault, input bit eob_last);
		int i;
		int eob_pos;
		int n;
		eob_pos = -1;
		case (fault)
			FAULT_SYNC0:   frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(255, 1));
			FAULT_SYNC1:   frame_buf[1] = frame_buf[1] ^ 8'($urandom_range(255, 1));
			FAULT_SUM: begin
				frame_buf[FRAME_N - 1] = frame_buf[FRAME_N - 1] ^ 8'($urandom_range(255, 1));
			end
			FAULT_EOB_MID: eob_pos = $urandom_range(FRAME_N - 2);
			FAULT_NOISE_LEAD: begin
				n = $urandom_range(6, 1);
				repeat (n)
					push_byte(8'($urandom()), 1'b0);
			end
			default: ;
		endcase
		for (i = 0; i < FRAME_N; i++)
			push_byte(frame_buf[i], (eob_last && i == FRAME_N - 1) || i == eob_pos);
	endtask

	function automatic imufp_pkg::result_t random_fields(input logic [15:0] yaw);
		imufp_pkg::result_t f;
		f = '0;
		f.gyro_x        = 16'($urandom());
		f.gyro_y        = 16'($urandom());
		f.gyro_z        = 16'($urandom());
		f.yaw_angle     = yaw;
		f.roll_angle    = 16'($urandom());
		f.pitch_angle   = 16'($urandom());
		f.device_status = 8'($urandom());
		return f;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// output checker: every transaction against the oldest decoded frame
	always @(posedge clk) begin : frame_check
		imufp_pkg::result_t want;
		imufp_pkg::result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_frames.size() == 0) begin
				$display("%0t ns: unexpected frame, expected none, actual frames_seen %0d",
				         $time, got.frames_seen);
				errors++;
			end else begin
				want = pending_frames.pop_front();
				check_field("gyro_x",        want.gyro_x,        got.gyro_x);
				check_field("gyro_y",        want.gyro_y,        got.gyro_y);
				check_field("gyro_z",        want.gyro_z,        got.gyro_z);
				check_field("yaw_angle",     want.yaw_angle,     got.yaw_angle);
				check_field("roll_angle",    want.roll_angle,    got.roll_angle);
				check_field("pitch_angle",   want.pitch_angle,   got.pitch_angle);
				check_field("device_status", want.device_status, got.device_status);
				check_field("turn_total",    want.turn_total,    got.turn_total);
				check_field("unwrapped_yaw", want.unwrapped_yaw, got.unwrapped_yaw);
				check_field("frames_seen",   want.frames_seen,   got.frames_seen);
			end
		end
	end

	initial begin : stimulus
		imufp_pkg::result_t f;
		frame_row_t  row;
		int          i;
		int          k;
		int          rnd;
		int          start_bytes;
		frame_fault_t fault;

		clk             = 1'b0;
		arst_n          = 1'b0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = 8'h00;
		s_axis_tlast    = 1'b0;
		errors          = 0;
		typed_pending   = 1'b0;
		link_bytes_sent = 0;
		last_yaw        = 16'h0000;
		turn_count      = 0;
		frame_count     = 16'h0000;
		clear_link_win();
		send_idle_pct   = 32;
		recv_idle_pct   = 47;

		// Directed frames. The first is compared with a last yaw of zero
		// straight out of reset; then full-scale fields, the turn threshold
		// exactly and one past it both ways, bad sync, bad sum, noise ahead,
		// end of buffer on the matching byte and inside a frame, and a plain frame.
		directed_rows = '{
			'{FAULT_NONE, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			  8'h00, 1'b1, 16'h0000, 32'd0, 16'd1},
			'{FAULT_NONE, 1'b0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF,
			  8'hFF, 1'b1, 16'hFFFF, 32'd29535, 16'd2},
			'{FAULT_NONE, 1'b0, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000,
			  8'h00, 1'b1, 16'h0000, 32'd0, 16'd3},
			'{FAULT_NONE, 1'b0, 16'h0001, 16'hFFFF, 16'h00FF, 16'd30000, 16'hFF00, 16'h0100,
			  8'h5A, 1'b1, 16'h0000, 32'd30000, 16'd4},
			'{FAULT_NONE, 1'b0, 16'h5A5A, 16'hA5A5, 16'h0F0F, 16'd60001, 16'hF0F0, 16'h3C3C,
			  8'hC3, 1'b1, 16'hFFFF, 32'd24001, 16'd5},
			'{FAULT_NONE, 1'b0, 16'h1234, 16'hEDCB, 16'h0000, 16'd30000, 16'h4321, 16'hBCDE,
			  8'h01, 1'b1, 16'h0000, 32'd30000, 16'd6},
			'{FAULT_NONE, 1'b0, 16'hFFFF, 16'h0001, 16'h8001, 16'd0, 16'h7FFE, 16'h0000,
			  8'h80, 1'b1, 16'h0000, 32'd0, 16'd7},
			'{FAULT_SYNC0, 1'b0, 16'h1111, 16'h2222, 16'h3333, 16'd100, 16'h4444, 16'h5555,
			  8'h66, 1'b0, 16'h0000, 32'd0, 16'd0},
			'{FAULT_SYNC1, 1'b0, 16'h7777, 16'h8888, 16'h9999, 16'd200, 16'hAAAA, 16'hBBBB,
			  8'hCC, 1'b0, 16'h0000, 32'd0, 16'd0},
			'{FAULT_SUM, 1'b0, 16'hDDDD, 16'hEEEE, 16'hFFFF, 16'd300, 16'h0000, 16'h1111,
			  8'h22, 1'b0, 16'h0000, 32'd0, 16'd0},
			'{FAULT_NOISE_LEAD, 1'b0, 16'h0102, 16'h0304, 16'h0506, 16'd65000, 16'h0708,
			  16'h090A, 8'h0B, 1'b0, 16'h0000, 32'd0, 16'd0},
			'{FAULT_NONE, 1'b1, 16'hF00D, 16'hBEEF, 16'hCAFE, 16'd100, 16'hFACE, 16'hD00D,
			  8'h7F, 1'b0, 16'h0000, 32'd0, 16'd0},
			'{FAULT_EOB_MID, 1'b0, 16'h2468, 16'h1357, 16'h9BDF, 16'd5000, 16'hACE0, 16'h8642,
			  8'h5A, 1'b0, 16'h0000, 32'd0, 16'd0},
			'{FAULT_NONE, 1'b0, 16'h0F1E, 16'h2D3C, 16'h4B5A, 16'd35000, 16'h6978, 16'h8796,
			  8'hA5, 1'b0, 16'h0000, 32'd0, 16'd0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 14; i++) begin
			row = directed_rows[i];
			f = '0;
			f.gyro_x        = row.gx;
			f.gyro_y        = row.gy;
			f.gyro_z        = row.gz;
			f.yaw_angle     = row.yaw;
			f.roll_angle    = row.roll;
			f.pitch_angle   = row.pitch;
			f.device_status = row.status;
			if (row.typed) begin
				typed_result               = f;
				typed_result.turn_total    = row.turns;
				typed_result.unwrapped_yaw = row.unwrap;
				typed_result.frames_seen   = row.frames;
				typed_pending              = 1'b1;
			end
			build_frame(f, 16'h0000);
			send_frame(row.fault, row.eob_last);
		end

		// Random frames, mostly intact, some damaged; idling swaps sides at
		// each third and stops for the last one.
		start_bytes = link_bytes_sent;
		while (link_bytes_sent - start_bytes < RANDOM_LEN) begin
			k = link_bytes_sent - start_bytes;
			if (k < RANDOM_LEN / 3) begin
				send_idle_pct = 32;
				recv_idle_pct = 47;
			end else if (k < 2 * RANDOM_LEN / 3) begin
				send_idle_pct = 47;
				recv_idle_pct = 32;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			rnd = $urandom_range(99);
			if (rnd < 70)
				fault = FAULT_NONE;
			else if (rnd < 74)
				fault = FAULT_SYNC0;
			else if (rnd < 78)
				fault = FAULT_SYNC1;
			else if (rnd < 86)
				fault = FAULT_SUM;
			else if (rnd < 92)
				fault = FAULT_EOB_MID;
			else
				fault = FAULT_NOISE_LEAD;
			build_frame(random_fields(pick_yaw()), 16'($urandom()));
			send_frame(fault, $urandom_range(9) == 0);
		end

		// drop tvalid on the edge that took the last byte
		s_axis_tvalid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
